// File: rtl/tttpf_pkg.sv
// Shared types and constants of the tiered threshold peak finder.
package tttpf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int THR_W     = 23;
  localparam int MISS_W    = 16;
  localparam int INDEX_W   = 16;
  localparam int LEVEL_W   = 3;
  // Ten times a level threshold fits in 27 bits unsigned.
  localparam int LVL_W     = 27;
  // Ten times a sample or a sample difference fits in 30 bits signed.
  localparam int PROD_W    = 30;
  localparam int CFG_IDX_W = 1;

  localparam int LEVEL_SCALE = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_CODE      = 1'd1;

  localparam logic [THR_W-1:0]  THR_RESET  = 23'd60;
  localparam logic [MISS_W-1:0] MISS_RESET = 16'd99;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] peak_index;
    logic               found;
    logic [LEVEL_W-1:0] level_used;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic             test;
    logic             clear;
    logic             thr_we;
    logic [THR_W-1:0] thr_val;
  } seq_ctl_t;

endpackage

// File: rtl/tttpf_level.sv
// One threshold level: scaled threshold, compare pair and first-hit capture.
module tttpf_level #(
  parameter int LEVEL = 0,
  parameter int IW    = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tttpf_pkg::seq_ctl_t                   ctl,
  input  logic signed [tttpf_pkg::PROD_W-1:0]   vt,
  input  logic signed [tttpf_pkg::PROD_W-1:0]   dt,
  input  logic [IW-1:0]                         pos,
  output logic                                  hit_o,
  output logic [IW-1:0]                         idx_o
);

  localparam logic [tttpf_pkg::LVL_W-1:0] MULT =
    tttpf_pkg::LVL_W'(tttpf_pkg::LEVEL_SCALE - LEVEL);
  localparam logic [tttpf_pkg::LVL_W-1:0] LVL_RESET =
    tttpf_pkg::LVL_W'(tttpf_pkg::THR_RESET) * MULT;

  logic [tttpf_pkg::LVL_W-1:0]         lvl_r;
  logic [tttpf_pkg::LVL_W-1:0]         lvl_nxt;
  logic                                hit_r;
  logic                                hit_nxt;
  logic [IW-1:0]                       idx_r;
  logic signed [tttpf_pkg::PROD_W-1:0] lvl_s;
  logic                                v_hit;
  logic                                d_hit;
  logic                                new_hit;

  // The scaled threshold is worked out once, when the base threshold is written.
  assign lvl_nxt = tttpf_pkg::LVL_W'(ctl.thr_val) * MULT;
  assign lvl_s   = $signed({{(tttpf_pkg::PROD_W - tttpf_pkg::LVL_W){1'b0}}, lvl_r});

  assign v_hit   = vt > lvl_s;
  assign d_hit   = dt > lvl_s;
  assign new_hit = ctl.test && !hit_r && (v_hit || d_hit);

  assign hit_o   = hit_r || new_hit;
  assign idx_o   = new_hit ? (v_hit ? pos : pos + IW'(1)) : idx_r;
  assign hit_nxt = ctl.clear ? 1'b0 : hit_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= LVL_RESET;
      hit_r <= 1'b0;
    end else begin
      if (ctl.thr_we) begin
        lvl_r <= lvl_nxt;
      end
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_o;
  end

endmodule

// File: rtl/tttpf_report.sv
// Picks the strictest level that hit and holds the result item for the output.
module tttpf_report #(
  parameter int NUM_LEVELS = 5,
  parameter int IW         = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [NUM_LEVELS-1:0]          hit,
  input  logic [IW-1:0]                  idx [NUM_LEVELS],
  input  logic [tttpf_pkg::MISS_W-1:0]   miss_code,
  input  logic                           overflow,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tttpf_pkg::out_item_t           out_item
);

  tttpf_pkg::out_item_t sel;
  tttpf_pkg::out_item_t out_item_r;
  logic                 out_valid_r;

  // Walk from the loosest level down so that the strictest hit wins.
  always_comb begin
    sel.peak_index = tttpf_pkg::INDEX_W'(miss_code);
    sel.found      = 1'b0;
    sel.level_used = '0;
    sel.overflow   = overflow;
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        sel.peak_index = tttpf_pkg::INDEX_W'(idx[k]);
        sel.found      = 1'b1;
        sel.level_used = tttpf_pkg::LEVEL_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= sel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/tiered_threshold_peak_finder_core.sv
// Top level of the tiered threshold peak finder.
//
//   port group | direction | carries
//   in_*       | input     | one sample with its last mark per item
//   out_*      | output    | one report item per sequence, on the last sample
//   cfg_*      | input     | writes of base threshold and miss code
//
// One item is taken every cycle unless in_stall is high; an item passes the input
// register and is tested at all levels at once while it is held there, so a
// report is registered when its last sample leaves the input register.
// Synchronous reset clears all control state; there is no clearing pass.
// Only a last sample waits in the input register while the output register
// is full and stalled; other samples keep flowing.
module tiered_threshold_peak_finder_core #(
  parameter int MAX_SAMPLES = 1024,
  parameter int NUM_LEVELS  = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tttpf_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tttpf_pkg::out_item_t              out_item,
  input  logic                              cfg_we,
  input  logic [tttpf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tttpf_pkg::THR_W-1:0]       cfg_wdata
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  tttpf_pkg::in_item_t                   in_item_r;
  logic                                  in_vld_r;
  logic signed [tttpf_pkg::SAMPLE_W-1:0] prev_r;
  logic [CW-1:0]                         cnt_r;
  logic                                  ovf_r;
  logic [tttpf_pkg::MISS_W-1:0]          miss_code_r;

  logic                                  out_free;
  logic                                  adv;
  logic                                  in_range;
  logic [IW-1:0]                         pos;
  logic signed [tttpf_pkg::SAMPLE_W:0]   diff;
  logic signed [tttpf_pkg::PROD_W-1:0]   vt;
  logic signed [tttpf_pkg::PROD_W-1:0]   dt;
  logic                                  thr_we;
  logic                                  miss_we;
  tttpf_pkg::seq_ctl_t                   ctl;
  logic [NUM_LEVELS-1:0]                 hit;
  logic [IW-1:0]                         idx [NUM_LEVELS];

  assign out_free = !out_valid || !out_stall;
  assign adv      = in_vld_r && (!in_item_r.last || out_free);
  assign in_stall = in_vld_r && in_item_r.last && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // Samples past the size bound are neither counted nor tested.
  assign in_range = cnt_r < CW'(MAX_SAMPLES);
  assign pos      = cnt_r[IW-1:0] - IW'(1);

  assign diff = (tttpf_pkg::SAMPLE_W + 1)'(in_item_r.sample) -
                (tttpf_pkg::SAMPLE_W + 1)'(prev_r);
  assign vt   = (tttpf_pkg::PROD_W'(prev_r) <<< 3) + (tttpf_pkg::PROD_W'(prev_r) <<< 1);
  assign dt   = (tttpf_pkg::PROD_W'(diff) <<< 3) + (tttpf_pkg::PROD_W'(diff) <<< 1);

  always_comb begin
    thr_we  = 1'b0;
    miss_we = 1'b0;
    unique case (cfg_idx)
      tttpf_pkg::CFG_BASE_THRESHOLD: thr_we  = cfg_we;
      tttpf_pkg::CFG_MISS_CODE:      miss_we = cfg_we;
      default: begin
        thr_we  = 1'b0;
        miss_we = 1'b0;
      end
    endcase
  end

  assign ctl.test    = adv && in_range && (cnt_r != '0);
  assign ctl.clear   = adv && in_item_r.last;
  assign ctl.thr_we  = thr_we;
  assign ctl.thr_val = cfg_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_code_r <= tttpf_pkg::MISS_RESET;
    end else if (miss_we) begin
      miss_code_r <= cfg_wdata[tttpf_pkg::MISS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      if (in_item_r.last) begin
        prev_r <= '0;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (in_range) begin
        prev_r <= in_item_r.sample;
        cnt_r  <= cnt_r + CW'(1);
      end else begin
        ovf_r  <= 1'b1;
      end
    end
  end

  for (genvar k = 0; k < NUM_LEVELS; k++) begin : g_level
    tttpf_level #(
      .LEVEL (k),
      .IW    (IW)
    ) u_level (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .vt    (vt),
      .dt    (dt),
      .pos   (pos),
      .hit_o (hit[k]),
      .idx_o (idx[k])
    );
  end

  tttpf_report #(
    .NUM_LEVELS (NUM_LEVELS),
    .IW         (IW)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && in_item_r.last),
    .hit       (hit),
    .idx       (idx),
    .miss_code (miss_code_r),
    .overflow  (ovf_r || !in_range),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // A report appears only after a last sample has been processed.
  a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(adv && in_item_r.last))
    else $error("report without a processed last sample");

  // The sample count never runs past the size bound.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SAMPLES))
    else $error("sample count beyond bound");

  // Every level starts the next sequence with no hit.
  a_hits_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_item_r.last) |=> (hit == '0) || ctl.test)
    else $error("level hits not cleared at end of sequence");

  // A held sample is not lost or overwritten while it waits.
  a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r && $stable(in_item_r))
    else $error("waiting sample lost");

  // A miss reports level zero.
  a_miss_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.level_used == '0))
    else $error("miss with nonzero level");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the tiered threshold peak finder core.
module testbench;

  localparam int SAMPLE_LIMIT = 1024;
  localparam int LEVELS       = 5;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tttpf_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall = 1'b0;
  tttpf_pkg::out_item_t out_item;
  logic cfg_we;
  logic [tttpf_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tttpf_pkg::THR_W-1:0] cfg_wdata;

  tiered_threshold_peak_finder_core #(
    .MAX_SAMPLES(SAMPLE_LIMIT),
    .NUM_LEVELS (LEVELS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted registers and per-profile search state.
  logic [tttpf_pkg::THR_W-1:0] model_thr;
  logic [tttpf_pkg::MISS_W-1:0] model_miss;
  logic signed [tttpf_pkg::SAMPLE_W-1:0] prev_value;
  int unsigned profile_len;
  bit level_hit[LEVELS];
  logic [9:0] level_index[LEVELS];
  bit profile_overflow;

  tttpf_pkg::out_item_t pending_reports[$];

  int mismatches = 0;
  int cycle_count = 0;
  int samples_sent = 0;
  int profiles_sent = 0;
  int reports_checked = 0;
  int overflow_reports = 0;
  int found_reports = 0;
  int stall_left = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  longint gen_prev = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic clear_profile();
    prev_value = '0;
    profile_len = 0;
    profile_overflow = 1'b0;
    for (int k = 0; k < LEVELS; k++) begin
      level_hit[k] = 1'b0;
      level_index[k] = '0;
    end
  endtask

  // Runs one sample through the predicted search; a last sample yields a report.
  task automatic advance_peak_search(input logic signed [tttpf_pkg::SAMPLE_W-1:0] value,
                                     input logic is_last);
    longint cur;
    longint vt;
    longint dt;
    longint lvl;
    tttpf_pkg::out_item_t rep;
    cur = value;
    if (profile_len >= SAMPLE_LIMIT) begin
      profile_overflow = 1'b1;
    end else begin
      if (profile_len >= 1) begin
        vt = longint'(prev_value) * 10;
        dt = (cur - longint'(prev_value)) * 10;
        for (int k = 0; k < LEVELS; k++) begin
          lvl = longint'(10 - k) * longint'(model_thr);
          if (!level_hit[k]) begin
            if (vt > lvl) begin
              level_hit[k] = 1'b1;
              level_index[k] = 10'(profile_len - 1);
            end else if (dt > lvl) begin
              level_hit[k] = 1'b1;
              level_index[k] = 10'(profile_len);
            end
          end
        end
      end
      prev_value = value;
      profile_len++;
    end
    if (is_last) begin
      rep = '0;
      rep.peak_index = model_miss;
      rep.overflow = profile_overflow;
      // Walk downward so the strictest level that hit wins.
      for (int k = LEVELS - 1; k >= 0; k--) begin
        if (level_hit[k]) begin
          rep.peak_index = tttpf_pkg::INDEX_W'(level_index[k]);
          rep.found = 1'b1;
          rep.level_used = tttpf_pkg::LEVEL_W'(k);
        end
      end
      pending_reports.insert(pending_reports.size(), rep);
      profiles_sent++;
      clear_profile();
    end
  endtask

  // Result side: checks each accepted report, then stalls for a drawn count.
  always @(posedge clk) begin
    tttpf_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("report arrived with none expected");
      end else begin
        want = pending_reports.pop_front();
        if (out_item.peak_index !== want.peak_index)
          report_mismatch($sformatf("peak_index %0d, expected %0d",
                                    out_item.peak_index, want.peak_index));
        if (out_item.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", out_item.found, want.found));
        if (out_item.level_used !== want.level_used)
          report_mismatch($sformatf("level_used %0d, expected %0d",
                                    out_item.level_used, want.level_used));
        if (out_item.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, expected %b",
                                    out_item.overflow, want.overflow));
        reports_checked++;
        if (want.overflow) overflow_reports++;
        if (want.found) found_reports++;
      end
      stall_left = out_quiet ? 0 : $urandom_range(0, 19);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [tttpf_pkg::SAMPLE_W-1:0] value,
                             input logic is_last);
    tttpf_pkg::in_item_t item;
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.sample = value;
    item.last = is_last;
    in_item <= item;
    in_valid <= 1'b1;
    advance_peak_search(value, is_last);
    do @(posedge clk); while (in_stall !== 1'b0);
    samples_sent++;
  endtask

  // Lets every outstanding report come back, then lets the design settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // The enable is a one-cycle strobe and drops before the next write, so back-to-back writes stay apart.
  task automatic write_reg(input logic [tttpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tttpf_pkg::THR_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    if (idx == tttpf_pkg::CFG_BASE_THRESHOLD) model_thr = data;
    else if (idx == tttpf_pkg::CFG_MISS_CODE) model_miss = data[tttpf_pkg::MISS_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // A flat profile of zeros with two spikes and the last mark on the final sample.
  task automatic send_long_profile(input int len, input int spike_pos,
                                   input logic signed [tttpf_pkg::SAMPLE_W-1:0] spike,
                                   input int tail_pos,
                                   input logic signed [tttpf_pkg::SAMPLE_W-1:0] tail_spike);
    logic signed [tttpf_pkg::SAMPLE_W-1:0] value;
    for (int i = 0; i < len; i++) begin
      value = '0;
      if (i == spike_pos) value = spike;
      if (i == tail_pos) value = tail_spike;
      send_sample(value, i == len - 1);
    end
  endtask

  // Draws a sample that often lands right on a level's boundary, either by value
  // or by the step from the previous sample.
  function automatic logic signed [tttpf_pkg::SAMPLE_W-1:0] shaped_sample();
    longint lvl;
    longint v;
    int pick;
    int jitter;
    logic signed [tttpf_pkg::SAMPLE_W-1:0] raw;
    pick = $urandom_range(0, 9);
    jitter = $urandom_range(0, 4);
    jitter = jitter - 2;
    lvl = (longint'(10 - $urandom_range(0, 4)) * longint'(model_thr)) / 10;
    raw = tttpf_pkg::SAMPLE_W'($urandom());
    if (pick < 2) v = raw;
    else if (pick < 6) v = lvl + jitter;
    else if (pick < 8) v = gen_prev + lvl + jitter;
    else v = jitter * 5 - lvl;
    if (v > 64'sd8388607) v = 64'sd8388607;
    if (v < -64'sd8388608) v = -64'sd8388608;
    gen_prev = v;
    return tttpf_pkg::SAMPLE_W'(v);
  endfunction

  task automatic test_reset_defaults();
    // One sample alone can never form a pair.
    send_sample(24'sd5, 1'b1);
    send_sample(24'sd61, 1'b0);
    send_sample(24'sd0, 1'b1);
    // Equal to the full threshold is not above it.
    send_sample(24'sd60, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(24'sd37, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd50, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b1);
    finish_phase();
  endtask

  task automatic test_extremes();
    write_reg(tttpf_pkg::CFG_BASE_THRESHOLD, '0);
    write_reg(tttpf_pkg::CFG_MISS_CODE, '0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b1);
    finish_phase();
    write_reg(tttpf_pkg::CFG_BASE_THRESHOLD, 23'h7FFFFF);
    write_reg(tttpf_pkg::CFG_MISS_CODE, 23'h7FFFFF);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh800000, 1'b1);
    finish_phase();
  endtask

  task automatic test_long_profiles();
    write_reg(tttpf_pkg::CFG_BASE_THRESHOLD, 23'd100);
    write_reg(tttpf_pkg::CFG_MISS_CODE, 23'd7);
    in_quiet = 1'b1;
    // Too long: the last step inside the bound hits, while a larger spike in
    // the ignored tail must not.
    send_long_profile(SAMPLE_LIMIT + 6, SAMPLE_LIMIT - 1, 24'sd200,
                      SAMPLE_LIMIT + 2, 24'sd5000);
    in_quiet = 1'b0;
    finish_phase();
  endtask

  task automatic test_random_profiles();
    int target;
    int pick;
    int n_profiles;
    int len;
    logic [tttpf_pkg::THR_W-1:0] thr;
    logic [tttpf_pkg::THR_W-1:0] miss_word;
    target = samples_sent + 250;
    while (samples_sent < target) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 5);
      case (pick)
        0: thr = '0;
        1: thr = 23'h7FFFFF;
        2: thr = tttpf_pkg::THR_W'($urandom_range(1, 200));
        3: thr = tttpf_pkg::THR_W'($urandom());
        default: thr = tttpf_pkg::THR_W'($urandom_range(1, 5000));
      endcase
      write_reg(tttpf_pkg::CFG_BASE_THRESHOLD, thr);
      miss_word = tttpf_pkg::THR_W'($urandom());
      pick = $urandom_range(0, 5);
      if (pick == 0) miss_word[tttpf_pkg::MISS_W-1:0] = '0;
      else if (pick == 1) miss_word[tttpf_pkg::MISS_W-1:0] = '1;
      write_reg(tttpf_pkg::CFG_MISS_CODE, miss_word);
      n_profiles = $urandom_range(2, 6);
      for (int p = 0; p < n_profiles; p++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 12);
        gen_prev = 0;
        for (int i = 0; i < len; i++)
          send_sample(shaped_sample(), i == len - 1);
      end
      finish_phase();
    end
    in_quiet = 1'b0;
    out_quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    model_thr = tttpf_pkg::THR_RESET;
    model_miss = tttpf_pkg::MISS_RESET;
    clear_profile();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_long_profiles();
    test_random_profiles();
    finish_phase();
    $display("Ran %0d samples in %0d profiles; %0d reports checked, %0d with a peak.",
             samples_sent, profiles_sent, reports_checked, found_reports);
    $display("%0d reports flagged an over-long profile; %0d mismatches.",
             overflow_reports, mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
